/* hdl/ciou_pkg.sv */
`default_nettype none
package ciou_pkg;

  // configuration register map
  localparam int REG_IDX_W = 1;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [REG_IDX_W-1:0] REG_IOU_THRESHOLD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ADJ_WINDOW = 1'b1;

  // register widths and reset values
  localparam int THR_W = 17;
  localparam int WIN_W = 8;
  localparam logic [THR_W-1:0] THR_RESET = '0;
  localparam logic [WIN_W-1:0] WIN_RESET = 8'd1;

endpackage
`default_nettype wire

/* hdl/ciou_in_if.sv */
`default_nettype none
interface ciou_in_if #(
  parameter int COORD_WIDTH = 24,
  parameter int ID_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] box_a_min_x;
  logic signed [COORD_WIDTH-1:0] box_a_min_y;
  logic signed [COORD_WIDTH-1:0] box_a_max_x;
  logic signed [COORD_WIDTH-1:0] box_a_max_y;
  logic signed [COORD_WIDTH-1:0] box_b_min_x;
  logic signed [COORD_WIDTH-1:0] box_b_min_y;
  logic signed [COORD_WIDTH-1:0] box_b_max_x;
  logic signed [COORD_WIDTH-1:0] box_b_max_y;
  logic [ID_WIDTH-1:0] id_current;
  logic [ID_WIDTH-1:0] id_candidate;

  modport source(
    output valid, box_a_min_x, box_a_min_y, box_a_max_x, box_a_max_y,
    output box_b_min_x, box_b_min_y, box_b_max_x, box_b_max_y,
    output id_current, id_candidate,
    input ready
  );
  modport sink(
    input valid, box_a_min_x, box_a_min_y, box_a_max_x, box_a_max_y,
    input box_b_min_x, box_b_min_y, box_b_max_x, box_b_max_y,
    input id_current, id_candidate,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/ciou_out_if.sv */
`default_nettype none
interface ciou_out_if #(
  parameter int RATIO_FRAC_BITS = 16
);
  logic valid;
  logic ready;
  logic [RATIO_FRAC_BITS:0] iou_ratio;
  logic [RATIO_FRAC_BITS:0] overlap_over_a;
  logic [RATIO_FRAC_BITS:0] overlap_over_b;
  logic adjacent;
  logic accept;
  logic degenerate;

  modport source(
    output valid, iou_ratio, overlap_over_a, overlap_over_b,
    output adjacent, accept, degenerate,
    input ready
  );
  modport sink(
    input valid, iou_ratio, overlap_over_a, overlap_over_b,
    input adjacent, accept, degenerate,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/ciou_frac_div.sv */
`default_nettype none
// pipelined restoring divider: q = floor(num * 2^F / den), num <= den
// one quotient bit per stage, stage j loads when en[j] is high
module ciou_frac_div #(
  parameter int DW = 49,
  parameter int F = 16
) (
  input  wire logic          clk,
  input  wire logic [F:0]    en,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [F:0]    q
);

  logic [DW-1:0] r_r [F+1];
  logic [DW-1:0] d_r [F+1];
  logic [F:0]    q_r [F+1];

  // integer bit: num and den compared directly
  logic          ge0;
  logic [DW-1:0] r0_nxt;
  assign ge0 = (num >= den);
  assign r0_nxt = ge0 ? num - den : num;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r[0] <= r0_nxt;
      d_r[0] <= den;
      q_r[0] <= {{F{1'b0}}, ge0};
    end
  end

  // fraction bits: shift remainder, trial subtract
  for (genvar j = 1; j <= F; j++) begin : g_step
    logic [DW:0]   sh;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] r_nxt;
    assign sh = {r_r[j-1], 1'b0};
    assign ge = (sh >= {1'b0, d_r[j-1]});
    assign diff = sh - {1'b0, d_r[j-1]};
    assign r_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];

    always_ff @(posedge clk) begin
      if (en[j]) begin
        r_r[j] <= r_nxt;
        d_r[j] <= d_r[j-1];
        q_r[j] <= {q_r[j-1][F-1:0], ge};
      end
    end
  end

  assign q = q_r[F];

endmodule
`default_nettype wire

/* hdl/loop_candidate_box_iou_filter.sv */
`default_nettype none
// Box overlap filter for loop-closure candidates. Each item is a pair of
// axis-aligned boxes plus two submap indices; the result gives IoU and the
// overlap over each box in unsigned Q1.RATIO_FRAC_BITS, the adjacency flag,
// the degenerate flag and the accept decision. The block takes one item
// per cycle unless back-pressure fills the pipeline, which is an input
// register, a stage of corner differences, a stage of multipliers, a union
// stage, one stage per quotient bit in three parallel restoring dividers and
// an output register. Each stage stalls only when it is full and the next
// one is stalled, so bubbles are squeezed out under back-pressure.
// Configuration sits behind an APB write/read port: iou_threshold at 0x0,
// adjacency_window at 0x4; change them only while the pipeline is empty.
module loop_candidate_box_iou_filter #(
  parameter int COORD_WIDTH = 24,
  parameter int RATIO_FRAC_BITS = 16,
  parameter int ID_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ciou_in_if.sink   in_ch,
  ciou_out_if.source out_ch,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [ciou_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ciou_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ciou_pkg::CFG_DATA_W-1:0] prdata,
  output logic      pready
);

  localparam int CW = COORD_WIDTH;
  localparam int F = RATIO_FRAC_BITS;
  localparam int RW = F + 1;
  localparam int DXW = CW + 1;          // signed difference
  localparam int AW = 2 * CW + 2;       // signed area
  localparam int IW = 2 * CW;           // unsigned intersection
  localparam int DW = 2 * CW + 1;       // unsigned divider operands
  localparam int NS = F + 6;            // pipeline stages
  localparam int DS = 4;                // first divider stage
  localparam int OS = NS - 1;           // output stage
  localparam int THR_W = ciou_pkg::THR_W;
  localparam int WIN_W = ciou_pkg::WIN_W;
  localparam int CMPW = (RW > THR_W) ? RW : THR_W;

  // configuration registers
  logic [THR_W-1:0] thr_r;
  logic [WIN_W-1:0] win_r;
  logic [ciou_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  assign pready = 1'b1;
  assign reg_idx = paddr[ciou_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ciou_pkg::THR_RESET;
      win_r <= ciou_pkg::WIN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ciou_pkg::REG_IOU_THRESHOLD: thr_r <= pwdata[THR_W-1:0];
        ciou_pkg::REG_ADJ_WINDOW:    win_r <= pwdata[WIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ciou_pkg::REG_IOU_THRESHOLD:
        prdata = {{(ciou_pkg::CFG_DATA_W-THR_W){1'b0}}, thr_r};
      ciou_pkg::REG_ADJ_WINDOW:
        prdata = {{(ciou_pkg::CFG_DATA_W-WIN_W){1'b0}}, win_r};
    endcase
  end

  // valid bits and per-stage ready chain
  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ch.ready;
  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = ~v_r[i] | rdy[i+1];
  end
  // no item is taken while reset is held
  assign in_ch.ready = rdy[0] & rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_ch.valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: input register
  logic signed [CW-1:0] ax0_r, ay0_r, ax1_r, ay1_r;
  logic signed [CW-1:0] bx0_r, by0_r, bx1_r, by1_r;
  logic [ID_WIDTH-1:0]  id1_r, id2_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ax0_r <= in_ch.box_a_min_x;
      ay0_r <= in_ch.box_a_min_y;
      ax1_r <= in_ch.box_a_max_x;
      ay1_r <= in_ch.box_a_max_y;
      bx0_r <= in_ch.box_b_min_x;
      by0_r <= in_ch.box_b_min_y;
      bx1_r <= in_ch.box_b_max_x;
      by1_r <= in_ch.box_b_max_y;
      id1_r <= in_ch.id_current;
      id2_r <= in_ch.id_candidate;
    end
  end

  // stage 1: box extents, clipped overlap extents, index distance
  logic signed [DXW-1:0] dxa_nxt, dya_nxt, dxb_nxt, dyb_nxt;
  logic signed [CW-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic signed [DXW-1:0] w_s, h_s;
  logic [CW-1:0]         w_nxt, h_nxt;
  logic [ID_WIDTH-1:0]   idx_gap;
  logic                  adj_nxt;

  logic signed [DXW-1:0] dxa_r, dya_r, dxb_r, dyb_r;
  logic [CW-1:0]         w_r, h_r;
  logic                  adj1_r;

  always_comb begin
    dxa_nxt = DXW'(ax1_r) - DXW'(ax0_r);
    dya_nxt = DXW'(ay1_r) - DXW'(ay0_r);
    dxb_nxt = DXW'(bx1_r) - DXW'(bx0_r);
    dyb_nxt = DXW'(by1_r) - DXW'(by0_r);
    lo_x = (ax0_r > bx0_r) ? ax0_r : bx0_r;
    hi_x = (ax1_r < bx1_r) ? ax1_r : bx1_r;
    lo_y = (ay0_r > by0_r) ? ay0_r : by0_r;
    hi_y = (ay1_r < by1_r) ? ay1_r : by1_r;
    w_s = DXW'(hi_x) - DXW'(lo_x);
    h_s = DXW'(hi_y) - DXW'(lo_y);
    w_nxt = w_s[DXW-1] ? '0 : w_s[CW-1:0];
    h_nxt = h_s[DXW-1] ? '0 : h_s[CW-1:0];
    idx_gap = (id1_r >= id2_r) ? id1_r - id2_r : id2_r - id1_r;
    adj_nxt = ({{WIN_W{1'b0}}, idx_gap} <= {{ID_WIDTH{1'b0}}, win_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dxa_r  <= dxa_nxt;
      dya_r  <= dya_nxt;
      dxb_r  <= dxb_nxt;
      dyb_r  <= dyb_nxt;
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      adj1_r <= adj_nxt;
    end
  end

  // stage 2: areas and intersection
  logic signed [AW-1:0] area_a_r, area_b_r;
  logic [IW-1:0]        inter_r;
  logic                 adj2_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      area_a_r <= AW'(dxa_r) * AW'(dya_r);
      area_b_r <= AW'(dxb_r) * AW'(dyb_r);
      inter_r  <= IW'(w_r) * IW'(h_r);
      adj2_r   <= adj1_r;
    end
  end

  // stage 3: union and degenerate check
  logic signed [AW:0] uni;
  logic               degen_nxt;
  logic [DW-1:0]      num_r, den_u_r, den_a_r, den_b_r;
  logic               degen3_r, adj3_r;

  always_comb begin
    uni = (AW+1)'(area_a_r) + (AW+1)'(area_b_r) - (AW+1)'({1'b0, inter_r});
    degen_nxt = (area_a_r <= 0) | (area_b_r <= 0) | (uni <= 0);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      num_r    <= DW'(inter_r);
      den_u_r  <= uni[DW-1:0];
      den_a_r  <= area_a_r[DW-1:0];
      den_b_r  <= area_b_r[DW-1:0];
      degen3_r <= degen_nxt;
      adj3_r   <= adj2_r;
    end
  end

  // stages DS..DS+F: three dividers side by side
  logic [RW-1:0] q_iou, q_a, q_b;

  ciou_frac_div #(.DW(DW), .F(F)) u_div_iou (
    .clk(clk), .en(rdy[DS+F:DS]), .num(num_r), .den(den_u_r), .q(q_iou)
  );
  ciou_frac_div #(.DW(DW), .F(F)) u_div_a (
    .clk(clk), .en(rdy[DS+F:DS]), .num(num_r), .den(den_a_r), .q(q_a)
  );
  ciou_frac_div #(.DW(DW), .F(F)) u_div_b (
    .clk(clk), .en(rdy[DS+F:DS]), .num(num_r), .den(den_b_r), .q(q_b)
  );

  // flags ride alongside the divider stages
  logic [F:0] degen_p_r, adj_p_r;

  always_ff @(posedge clk) begin
    if (rdy[DS]) begin
      degen_p_r[0] <= degen3_r;
      adj_p_r[0]   <= adj3_r;
    end
    for (int j = 1; j <= F; j++) begin
      if (rdy[DS+j]) begin
        degen_p_r[j] <= degen_p_r[j-1];
        adj_p_r[j]   <= adj_p_r[j-1];
      end
    end
  end

  // output stage: zero ratios of degenerate pairs, threshold test
  logic          dg, aj;
  logic [RW-1:0] iou_m, ova_m, ovb_m;
  logic          acc_nxt;

  logic [RW-1:0] iou_r, ova_r, ovb_r;
  logic          adj_o_r, acc_o_r, degen_o_r;

  always_comb begin
    dg = degen_p_r[F];
    aj = adj_p_r[F];
    iou_m = dg ? '0 : q_iou;
    ova_m = dg ? '0 : q_a;
    ovb_m = dg ? '0 : q_b;
    acc_nxt = ~aj & ~dg & (CMPW'(iou_m) > CMPW'(thr_r));
  end

  always_ff @(posedge clk) begin
    if (rdy[OS]) begin
      iou_r     <= iou_m;
      ova_r     <= ova_m;
      ovb_r     <= ovb_m;
      adj_o_r   <= aj;
      acc_o_r   <= acc_nxt;
      degen_o_r <= dg;
    end
  end

  assign out_ch.valid          = v_r[OS];
  assign out_ch.iou_ratio      = iou_r;
  assign out_ch.overlap_over_a = ova_r;
  assign out_ch.overlap_over_b = ovb_r;
  assign out_ch.adjacent       = adj_o_r;
  assign out_ch.accept         = acc_o_r;
  assign out_ch.degenerate     = degen_o_r;

endmodule
`default_nettype wire

/* test/tb_box_iou_checker.sv */
`default_nettype none
module tb_box_iou_checker (
  input wire logic clk,
  input wire logic rst_n,
  ciou_in_if.source in_ch,
  ciou_out_if.sink out_ch,
  input wire logic [ciou_pkg::THR_W-1:0] iou_thr,
  input wire logic [ciou_pkg::WIN_W-1:0] adj_win,
  output int n_errors,
  output int n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [16:0] iou;
    logic [16:0] ova;
    logic [16:0] ovb;
    logic adj;
    logic acc;
    logic degen;
  } pair_verdict_t;

  pair_verdict_t verdict_q[$];

  // floor(num * 2^16 / den), num <= den
  function automatic logic [16:0] q16_ratio(longint num, longint den);
    longint q, r;
    q = 0;
    r = num;
    if (r >= den) begin
      q = 1;
      r -= den;
    end
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q[16:0];
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic pair_verdict_t judge_pair();
    pair_verdict_t v;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint area_a, area_b, w, h, ovl, uni, idx_gap;
    ax0 = longint'(in_ch.box_a_min_x);
    ay0 = longint'(in_ch.box_a_min_y);
    ax1 = longint'(in_ch.box_a_max_x);
    ay1 = longint'(in_ch.box_a_max_y);
    bx0 = longint'(in_ch.box_b_min_x);
    by0 = longint'(in_ch.box_b_min_y);
    bx1 = longint'(in_ch.box_b_max_x);
    by1 = longint'(in_ch.box_b_max_y);
    area_a = (ax1 - ax0) * (ay1 - ay0);
    area_b = (bx1 - bx0) * (by1 - by0);
    w = lmax(0, lmin(ax1, bx1) - lmax(ax0, bx0));
    h = lmax(0, lmin(ay1, by1) - lmax(ay0, by0));
    ovl = w * h;
    idx_gap = longint'(in_ch.id_current) - longint'(in_ch.id_candidate);
    if (idx_gap < 0) idx_gap = -idx_gap;
    v = '0;
    v.adj = idx_gap <= longint'(adj_win);
    v.degen = area_a <= 0 || area_b <= 0;
    if (!v.degen) begin
      uni = area_a + area_b - ovl;
      v.degen = uni <= 0;
      if (!v.degen) begin
        v.iou = q16_ratio(ovl, uni);
        v.ova = q16_ratio(ovl, area_a);
        v.ovb = q16_ratio(ovl, area_b);
      end
    end
    v.acc = !v.adj && !v.degen && (v.iou > iou_thr);
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  initial n_errors = 0;
  initial n_pending = 0;

  // predict on input item, compare on result item
  always @(posedge clk) begin
    pair_verdict_t e;
    if (rst_n && in_ch.valid && in_ch.ready)
      verdict_q.insert(verdict_q.size(), judge_pair());
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        e = verdict_q.pop_front();
        if (out_ch.iou_ratio !== e.iou) report_mismatch("iou_ratio", out_ch.iou_ratio, e.iou);
        if (out_ch.overlap_over_a !== e.ova)
          report_mismatch("overlap_over_a", out_ch.overlap_over_a, e.ova);
        if (out_ch.overlap_over_b !== e.ovb)
          report_mismatch("overlap_over_b", out_ch.overlap_over_b, e.ovb);
        if (out_ch.adjacent !== e.adj) report_mismatch("adjacent", out_ch.adjacent, e.adj);
        if (out_ch.accept !== e.acc) report_mismatch("accept", out_ch.accept, e.acc);
        if (out_ch.degenerate !== e.degen)
          report_mismatch("degenerate", out_ch.degenerate, e.degen);
      end
    end
    n_pending = verdict_q.size();
  end
endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ciou_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [ciou_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [ciou_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic [ciou_pkg::THR_W-1:0] thr_shadow = ciou_pkg::THR_RESET;
  logic [ciou_pkg::WIN_W-1:0] win_shadow = ciou_pkg::WIN_RESET;
  int n_errors, n_pending;
  int src_idle_pct = 0, snk_stall_pct = 0;

  ciou_in_if pair_in ();
  ciou_out_if verdict_out ();

  loop_candidate_box_iou_filter i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(pair_in.sink), .out_ch(verdict_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tb_box_iou_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(pair_in.source), .out_ch(verdict_out.sink),
    .iou_thr(thr_shadow), .adj_win(win_shadow), .n_errors(n_errors), .n_pending(n_pending)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("loop_candidate_box_iou_filter verification failed");
    $finish;
  end

  // receiver stalls at random
  initial verdict_out.ready = 0;
  always @(negedge clk)
    verdict_out.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);

  task automatic write_reg(logic [ciou_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= ciou_pkg::CFG_ADDR_W'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == ciou_pkg::REG_IOU_THRESHOLD) thr_shadow = val[ciou_pkg::THR_W-1:0];
    else win_shadow = val[ciou_pkg::WIN_W-1:0];
  endtask

  task automatic drain();
    pair_in.valid <= 0;
    while (n_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    unique case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(4000)) - 24'd2000;
      2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: return 24'($urandom_range(200)) - 24'd100;
    endcase
  endfunction

  // send one pair; waits for the handshake, valid stays up for a following item
  task automatic send_pair(logic [23:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y,
                           logic [15:0] ic, icand);
    while ($urandom_range(99) < src_idle_pct) begin
      pair_in.valid <= 0;
      @(negedge clk);
    end
    pair_in.valid <= 1;
    pair_in.box_a_min_x <= a0x; pair_in.box_a_min_y <= a0y;
    pair_in.box_a_max_x <= a1x; pair_in.box_a_max_y <= a1y;
    pair_in.box_b_min_x <= b0x; pair_in.box_b_min_y <= b0y;
    pair_in.box_b_max_x <= b1x; pair_in.box_b_max_y <= b1y;
    pair_in.id_current <= ic; pair_in.id_candidate <= icand;
    @(posedge clk);
    while (!pair_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_pair();
    logic [23:0] x0, y0, w, h, dx, dy;
    logic [15:0] ic;
    ic = 16'($urandom);
    if ($urandom_range(9) < 7) begin
      // well-formed overlapping-ish boxes
      x0 = rand_coord() >>> 1;
      y0 = rand_coord() >>> 1;
      w = 24'($urandom_range(1, 3000));
      h = 24'($urandom_range(1, 3000));
      dx = 24'($urandom_range(3000)) - 24'd1500;
      dy = 24'($urandom_range(3000)) - 24'd1500;
      send_pair(x0, y0, x0 + w, y0 + h, x0 + dx, y0 + dy,
                x0 + dx + 24'($urandom_range(1, 3000)), y0 + dy + 24'($urandom_range(1, 3000)),
                ic, $urandom_range(1) ? ic + 16'($urandom_range(6)) - 16'd3 : 16'($urandom));
    end else begin
      send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord(), ic, 16'($urandom));
    end
  endtask

  initial begin
    pair_in.valid = 0;
    {pair_in.box_a_min_x, pair_in.box_a_min_y, pair_in.box_a_max_x, pair_in.box_a_max_y} = '0;
    {pair_in.box_b_min_x, pair_in.box_b_min_y, pair_in.box_b_max_x, pair_in.box_b_max_y} = '0;
    pair_in.id_current = 0;
    pair_in.id_candidate = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // directed: identical, disjoint, nested, zero area, inverted, extremes
    send_pair(0, 0, 256, 256, 0, 0, 256, 256, 10, 20);
    send_pair(0, 0, 256, 256, 512, 512, 768, 768, 10, 20);
    send_pair(0, 0, 1024, 1024, 256, 256, 512, 512, 10, 20);
    send_pair(100, 100, 100, 300, 0, 0, 256, 256, 10, 20);
    send_pair(300, 300, 0, 0, 0, 0, 256, 256, 0, 65535);
    send_pair(0, 0, 256, 256, 256, 0, 0, 256, 5, 5);
    send_pair(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff,
              24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 65535, 0);
    send_pair(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 0, 0, 1, 1, 3, 4);
    send_pair(0, 0, 256, 256, 128, 0, 384, 256, 3, 5);
    send_pair(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 0, 0, 1, 1, 100, 102);
    drain();

    // walk the register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      unique case (ph % 4)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 80; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 80; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      unique case (ph)
        0: begin
          write_reg(ciou_pkg::REG_IOU_THRESHOLD, 0);
          write_reg(ciou_pkg::REG_ADJ_WINDOW, 0);
        end
        1: begin
          write_reg(ciou_pkg::REG_IOU_THRESHOLD, 17'h10000);
          write_reg(ciou_pkg::REG_ADJ_WINDOW, 255);
        end
        2: begin
          write_reg(ciou_pkg::REG_IOU_THRESHOLD, 17'h1ffff);
          write_reg(ciou_pkg::REG_ADJ_WINDOW, 1);
        end
        3: begin
          write_reg(ciou_pkg::REG_IOU_THRESHOLD, 17'h08000);
          write_reg(ciou_pkg::REG_ADJ_WINDOW, 2);
        end
        default: begin
          write_reg(ciou_pkg::REG_IOU_THRESHOLD, $urandom_range(17'h1ffff));
          write_reg(ciou_pkg::REG_ADJ_WINDOW, $urandom_range(255));
        end
      endcase
      for (int k = 0; k < 106; k++) random_pair();
      drain();
    end

    if (n_errors == 0) $display("loop_candidate_box_iou_filter verification clean");
    else $display("loop_candidate_box_iou_filter verification failed");
    $finish;
  end
endmodule
`default_nettype wire
